### sv/swm_pkg.sv
// Shared types and constants for the sliding window minimum block.
`default_nettype none
package swm_pkg;

  localparam int DATA_W = 32;
  localparam int SUM_W  = 64;
  localparam int WIN_W  = 11;
  localparam int APB_W  = 32;
  localparam int PADDR_W = 2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam data_t INT_MAX = data_t'(32'sh7FFF_FFFF);

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1);

  localparam logic [PADDR_W-1:0] WINDOW_SIZE_ADDR = PADDR_W'(0);

endpackage
`default_nettype wire

### sv/swm_min_unit.sv
// Shared signed minimum unit.
`default_nettype none
module swm_min_unit
  import swm_pkg::*;
(
  input  wire data_t a,
  input  wire data_t b,
  output data_t      y
);

  assign y = (a <= b) ? a : b;

endmodule
`default_nettype wire

### sv/swm_stack_mem.sv
// Single-port-write, registered-read stack memory.
`default_nettype none
module swm_stack_mem
  import swm_pkg::*;
#(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire data_t             wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output data_t                  rd_data
);

  data_t mem_r [DEPTH];
  data_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### sv/sliding_window_minimum_core.sv
// Sliding window minimum: two-stack queue with a shared minimum unit.
// Each accepted sample passes check and push, plus emit once the window is full; a drop
// passes drop and read-min (drop alone when it empties the drain stack), and a drain-stack
// refill reads and writes each moved sample. One transaction at a time: no new sample is
// taken until the state machine is back in idle.
// Reset: counts and sum clear, stack minima go to INT_MAX, window_size is 1; memories keep data.
`default_nettype none
module sliding_window_minimum_core
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire data_t               in_sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output data_t                    out_window_min,
  output sum_t                     out_min_sum,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [APB_W-1:0]    pwdata,
  output logic [APB_W-1:0]         prdata,
  output logic                     pready
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_TR_RD = 3'd2;
  localparam logic [2:0] ST_TR_WR = 3'd3;
  localparam logic [2:0] ST_DROP  = 3'd4;
  localparam logic [2:0] ST_RDMIN = 3'd5;
  localparam logic [2:0] ST_PUSH  = 3'd6;
  localparam logic [2:0] ST_EMIT  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [WIN_W-1:0] window_size_r;
  logic [CNT_W-1:0] push_count_r, push_count_nxt;
  logic [CNT_W-1:0] drain_count_r, drain_count_nxt;
  data_t            push_min_r, push_min_nxt;
  data_t            drain_min_r, drain_min_nxt;
  data_t            sample_r;
  sum_t             sum_r, sum_nxt;
  logic             out_valid_r, out_valid_nxt;
  data_t            out_min_r, out_min_nxt;
  sum_t             out_sum_r, out_sum_nxt;

  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] w_eff;
  logic [CMP_W-1:0] ws_ext;

  data_t            min_a, min_b, min_y;

  logic              push_wr_en, push_rd_en;
  logic [ADDR_W-1:0] push_wr_addr, push_rd_addr;
  data_t             push_rd_data;
  logic              drain_wr_en, drain_rd_en;
  logic [ADDR_W-1:0] drain_wr_addr, drain_rd_addr;
  data_t             drain_rd_data;

  logic              in_acc, cfg_wr, out_free;

  assign ws_ext = CMP_W'(window_size_r);
  always_comb begin
    priority if (window_size_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (ws_ext > CMP_W'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(ws_ext);
    end
  end

  assign held     = CNT_W'(push_count_r + drain_count_r);
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign prdata   = (paddr == WINDOW_SIZE_ADDR) ? APB_W'(window_size_r) : '0;

  assign out_valid      = out_valid_r;
  assign out_window_min = out_min_r;
  assign out_min_sum    = out_sum_r;

  swm_min_unit u_min (
    .a (min_a),
    .b (min_b),
    .y (min_y)
  );

  swm_stack_mem #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (ADDR_W)
  ) u_push_mem (
    .clk     (clk),
    .wr_en   (push_wr_en),
    .wr_addr (push_wr_addr),
    .wr_data (sample_r),
    .rd_en   (push_rd_en),
    .rd_addr (push_rd_addr),
    .rd_data (push_rd_data)
  );

  swm_stack_mem #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (ADDR_W)
  ) u_drain_mem (
    .clk     (clk),
    .wr_en   (drain_wr_en),
    .wr_addr (drain_wr_addr),
    .wr_data (min_y),
    .rd_en   (drain_rd_en),
    .rd_addr (drain_rd_addr),
    .rd_data (drain_rd_data)
  );

  always_comb begin
    logic [CNT_W-1:0] push_dec, drain_dec2;
    push_dec   = push_count_r - CNT_W'(1);
    drain_dec2 = drain_count_r - CNT_W'(2);

    state_nxt       = state_r;
    push_count_nxt  = push_count_r;
    drain_count_nxt = drain_count_r;
    push_min_nxt    = push_min_r;
    drain_min_nxt   = drain_min_r;
    sum_nxt         = sum_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_min_nxt     = out_min_r;
    out_sum_nxt     = out_sum_r;

    min_a = sample_r;
    min_b = push_min_r;

    push_wr_en    = 1'b0;
    push_wr_addr  = push_count_r[ADDR_W-1:0];
    push_rd_en    = 1'b0;
    push_rd_addr  = push_dec[ADDR_W-1:0];
    drain_wr_en   = 1'b0;
    drain_wr_addr = drain_count_r[ADDR_W-1:0];
    drain_rd_en   = 1'b0;
    drain_rd_addr = drain_dec2[ADDR_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (held < w_eff) begin
          state_nxt = ST_PUSH;
        end else if (drain_count_r == '0) begin
          state_nxt = ST_TR_RD;
        end else begin
          state_nxt = ST_DROP;
        end
      end
      ST_TR_RD: begin
        push_rd_en     = 1'b1;
        push_count_nxt = push_dec;
        state_nxt      = ST_TR_WR;
      end
      ST_TR_WR: begin
        min_a           = push_rd_data;
        min_b           = drain_min_r;
        drain_wr_en     = 1'b1;
        drain_min_nxt   = min_y;
        drain_count_nxt = drain_count_r + CNT_W'(1);
        if (push_count_r == '0) begin
          push_min_nxt = INT_MAX;
          state_nxt    = ST_DROP;
        end else begin
          state_nxt = ST_TR_RD;
        end
      end
      ST_DROP: begin
        drain_count_nxt = drain_count_r - CNT_W'(1);
        if (drain_count_r == CNT_W'(1)) begin
          drain_min_nxt = INT_MAX;
          state_nxt     = ST_CHECK;
        end else begin
          drain_rd_en = 1'b1;
          state_nxt   = ST_RDMIN;
        end
      end
      ST_RDMIN: begin
        drain_min_nxt = drain_rd_data;
        state_nxt     = ST_CHECK;
      end
      ST_PUSH: begin
        push_wr_en     = 1'b1;
        push_min_nxt   = min_y;
        push_count_nxt = push_count_r + CNT_W'(1);
        if (CNT_W'(held + CNT_W'(1)) == w_eff) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        min_a = push_min_r;
        min_b = drain_min_r;
        if (out_free) begin
          sum_nxt       = sum_r + SUM_W'(min_y);
          out_valid_nxt = 1'b1;
          out_min_nxt   = min_y;
          out_sum_nxt   = sum_r + SUM_W'(min_y);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      window_size_r <= WIN_RESET;
      push_count_r  <= '0;
      drain_count_r <= '0;
      push_min_r    <= INT_MAX;
      drain_min_r   <= INT_MAX;
      sum_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      push_count_r  <= push_count_nxt;
      drain_count_r <= drain_count_nxt;
      push_min_r    <= push_min_nxt;
      drain_min_r   <= drain_min_nxt;
      sum_r         <= sum_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_wr) begin
        window_size_r <= pwdata[WIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_sample;
    end
    out_min_r <= out_min_nxt;
    out_sum_r <= out_sum_nxt;
  end

endmodule
`default_nettype wire
